[hw/rtl/vsar_pkg.sv]
// shared types, event codes, masks and helpers of the scroll address register unit
package vsar_pkg;

   typedef enum logic [3:0] {
      FUNC_CTRL_WR    = 4'd0,
      FUNC_SCROLL_WR  = 4'd1,
      FUNC_ADDR_WR    = 4'd2,
      FUNC_STATUS_RD  = 4'd3,
      FUNC_DATA_RD    = 4'd4,
      FUNC_DATA_WR    = 4'd5,
      FUNC_INC_HORIZ  = 4'd6,
      FUNC_INC_VERT   = 4'd7,
      FUNC_COPY_HORIZ = 4'd8,
      FUNC_COPY_VERT  = 4'd9
   } func_type;

   localparam int ADDR_W = 15;

   localparam logic [ADDR_W-1:0] VERT_BITS        = 15'h7be0;
   localparam logic [ADDR_W-1:0] HORIZ_BITS       = 15'h041f;
   localparam logic [ADDR_W-1:0] CTRL_KEEP_MASK   = 15'h73ff;
   localparam logic [ADDR_W-1:0] SCROLL1_KEEP     = 15'h7fe0;
   localparam logic [ADDR_W-1:0] SCROLL2_KEEP     = 15'h0c1f;
   localparam logic [ADDR_W-1:0] ADDR1_KEEP       = 15'h00ff;
   localparam logic [ADDR_W-1:0] ADDR2_KEEP       = 15'h7f00;
   localparam logic [ADDR_W-1:0] STEP_ONE         = 15'd1;
   localparam logic [ADDR_W-1:0] STEP_ROW         = 15'd32;
   localparam logic [ADDR_W-1:0] STEP_RENDER      = 15'd33;
   localparam logic [4:0]        ROW_LAST_VISIBLE = 5'd29;
   localparam logic [4:0]        ROW_MAX          = 5'd31;
   localparam logic [4:0]        COL_MAX          = 5'd31;
   localparam logic [13:0]       NAME_TABLE_BASE  = 14'h2000;
   localparam logic [13:0]       ATTR_TABLE_BASE  = 14'h23c0;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 72;

   typedef struct packed {
      logic [ADDR_W-1:0] cur_addr;
      logic [ADDR_W-1:0] tmp_addr;
      logic [2:0]        fine_x;
      logic              toggle;
      logic              inc_by_row;
   } state_type;

   function automatic logic [13:0] tile_addr(input logic [ADDR_W-1:0] cur);
      tile_addr = NAME_TABLE_BASE | {2'b00, cur[11:0]};
   endfunction

   function automatic logic [13:0] attr_addr(input logic [ADDR_W-1:0] cur);
      attr_addr = ATTR_TABLE_BASE | {2'b00, cur[11:10], 4'b0000, cur[9:7], cur[4:2]};
   endfunction

endpackage

[hw/rtl/video_scroll_address_registers.sv]
// Scroll and video address register unit of a tile-based picture processor.
// One event beat enters on the req_ channel: req_tuser carries the event code
// (control, scroll or address write, status read, data read or write,
// horizontal or vertical increment, horizontal or vertical copy) and
// req_tdata the written byte and the rendering flag.
// For every event beat exactly one result beat leaves on the rsp_ channel with
// both addresses, fine X, the write toggle and the fetch addresses after it.
// An accepted beat is held in the input register; its result is loaded into
// the output register once that register is free, and is offered from there.
// Throughput: one event per cycle while results are taken; the state update
// is a single level of logic between the input and result registers.
// When rsp_tready is low the result register holds, the input register still
// takes one more beat, and req_tready then drops until the result is taken.
// Reset clears both addresses, fine X, the toggle, the increment mode and all
// valid flags; no result is pending after reset.
module video_scroll_address_registers (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] bus_value, [8] rendering_active, [15:9] zero
   input  logic [vsar_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [3:0] func
   input  logic [3:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [14:0] current_address, [29:15] temp_address, [32:30] fine_x,
   // [33] second_write, [47:34] tile_fetch_address,
   // [61:48] attribute_fetch_address, [64:62] fine_y, [71:65] zero
   output logic [vsar_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic                                in_valid_ff;
   logic                                in_valid_in;
   logic [3:0]                          in_func_ff;
   logic [7:0]                          in_value_ff;
   logic                                in_rend_ff;
   vsar_pkg::state_type                 state_ff;
   vsar_pkg::state_type                 state_in;
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [vsar_pkg::RSP_DATA_W-1:0]     out_data_ff;
   logic [vsar_pkg::RSP_DATA_W-1:0]     out_data_in;
   logic                                out_free;
   logic                                advance;
   logic                                req_fire;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   vsar_step u_step (
      .state            (state_ff),
      .func             (vsar_pkg::func_type'(in_func_ff)),
      .bus_value        (in_value_ff),
      .rendering_active (in_rend_ff),
      .next_state       (state_in)
   );

   always_comb begin
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      out_data_in  = {7'd0,
                      state_in.cur_addr[14:12],
                      vsar_pkg::attr_addr(state_in.cur_addr),
                      vsar_pkg::tile_addr(state_in.cur_addr),
                      state_in.toggle,
                      state_in.fine_x,
                      state_in.tmp_addr,
                      state_in.cur_addr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_func_ff  <= req_tuser;
         in_value_ff <= req_tdata[7:0];
         in_rend_ff  <= req_tdata[8];
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // state moves only together with a new result
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a result beat");

   // a pending result always mirrors the live state
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff[14:0] == state_ff.cur_addr
                        && out_data_ff[29:15] == state_ff.tmp_addr
                        && out_data_ff[33] == state_ff.toggle))
      else $error("result register out of step with state");

   // a new result needs an event in the input register
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result without an event");

   // empty input register never back-pressures
   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("stall with empty input register");

endmodule

[hw/rtl/vsar_step.sv]
// next-state logic for one register event
module vsar_step (
   input  vsar_pkg::state_type state,
   input  vsar_pkg::func_type  func,
   input  logic [7:0]          bus_value,
   input  logic                rendering_active,
   output vsar_pkg::state_type next_state
);

   logic [vsar_pkg::ADDR_W-1:0] data_step;
   logic [vsar_pkg::ADDR_W-1:0] tmp_wr;
   logic [4:0]                  row;

   always_comb begin
      data_step = state.inc_by_row ? vsar_pkg::STEP_ROW : vsar_pkg::STEP_ONE;
      tmp_wr    = {state.tmp_addr[14:8], bus_value};
      row       = state.cur_addr[9:5];
      next_state = state;
      case (func)
         vsar_pkg::FUNC_CTRL_WR: begin
            next_state.tmp_addr   = (state.tmp_addr & vsar_pkg::CTRL_KEEP_MASK)
                                  | {3'b000, bus_value[1:0], 10'd0};
            next_state.inc_by_row = bus_value[2];
         end
         vsar_pkg::FUNC_SCROLL_WR: begin
            if (!state.toggle) begin
               next_state.tmp_addr = (state.tmp_addr & vsar_pkg::SCROLL1_KEEP)
                                   | {10'd0, bus_value[7:3]};
               next_state.fine_x   = bus_value[2:0];
            end else begin
               next_state.tmp_addr = (state.tmp_addr & vsar_pkg::SCROLL2_KEEP)
                                   | {bus_value[2:0], 2'b00, bus_value[7:3], 5'd0};
            end
            next_state.toggle = ~state.toggle;
         end
         vsar_pkg::FUNC_ADDR_WR: begin
            if (!state.toggle) begin
               // high byte, bit 14 cleared
               next_state.tmp_addr = (state.tmp_addr & vsar_pkg::ADDR1_KEEP)
                                   | {1'b0, bus_value[5:0], 8'd0};
            end else begin
               next_state.tmp_addr = tmp_wr;
               next_state.cur_addr = tmp_wr;
            end
            next_state.toggle = ~state.toggle;
         end
         vsar_pkg::FUNC_STATUS_RD: begin
            next_state.toggle = 1'b0;
         end
         vsar_pkg::FUNC_DATA_RD: begin
            next_state.cur_addr = state.cur_addr + data_step;
         end
         vsar_pkg::FUNC_DATA_WR: begin
            next_state.cur_addr = state.cur_addr
                                + (rendering_active ? vsar_pkg::STEP_RENDER : data_step);
         end
         vsar_pkg::FUNC_INC_HORIZ: begin
            if (state.cur_addr[4:0] == vsar_pkg::COL_MAX) begin
               next_state.cur_addr[4:0] = 5'd0;
               next_state.cur_addr[10]  = ~state.cur_addr[10];
            end else begin
               next_state.cur_addr = state.cur_addr + vsar_pkg::STEP_ONE;
            end
         end
         vsar_pkg::FUNC_INC_VERT: begin
            if (state.cur_addr[14:12] != 3'b111) begin
               next_state.cur_addr[14:12] = state.cur_addr[14:12] + 3'd1;
            end else begin
               next_state.cur_addr[14:12] = 3'd0;
               if (row == vsar_pkg::ROW_LAST_VISIBLE) begin
                  next_state.cur_addr[9:5] = 5'd0;
                  next_state.cur_addr[11]  = ~state.cur_addr[11];
               end else if (row == vsar_pkg::ROW_MAX) begin
                  // attribute rows wrap without switching name table
                  next_state.cur_addr[9:5] = 5'd0;
               end else begin
                  next_state.cur_addr[9:5] = row + 5'd1;
               end
            end
         end
         vsar_pkg::FUNC_COPY_HORIZ: begin
            next_state.cur_addr = (state.cur_addr & vsar_pkg::VERT_BITS)
                                | (state.tmp_addr & vsar_pkg::HORIZ_BITS);
         end
         vsar_pkg::FUNC_COPY_VERT: begin
            next_state.cur_addr = (state.cur_addr & vsar_pkg::HORIZ_BITS)
                                | (state.tmp_addr & vsar_pkg::VERT_BITS);
         end
         default: begin
            next_state = state;
         end
      endcase
   end

endmodule

[test/video_scroll_address_registers_test.sv]
// testbench for the scroll and video address register unit: directed and random events
module video_scroll_address_registers_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] FUNC_FIRST_UNUSED = 4'd10;
   localparam logic [3:0] FUNC_LAST_UNUSED  = 4'd15;
   localparam int         WATCHDOG_LIMIT    = 2000;
   localparam int         LONG_HOLD_CYCLES  = 250;

   // one expected result beat, fields as the block reports them
   typedef struct packed {
      logic [14:0] cur_addr;
      logic [14:0] tmp_addr;
      logic [2:0]  fine_x;
      logic        second_write;
      logic [13:0] tile_addr;
      logic [13:0] attr_addr;
      logic [2:0]  fine_y;
   } scroll_view_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [vsar_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [3:0]                      req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [vsar_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // mirror of the block's registers
   logic [14:0] cur_addr   = '0;
   logic [14:0] tmp_addr   = '0;
   logic [2:0]  fine_x     = '0;
   logic        toggle     = 1'b0;
   logic        inc_by_row = 1'b0;

   scroll_view_type expected_views[$];
   scroll_view_type oldest_view;
   int              error_count   = 0;
   int              idle_cycles   = 0;
   int unsigned     tx_idle_pct   = 0;
   int unsigned     rx_stall_pct  = 0;
   int              rx_hold_left  = 0;

   video_scroll_address_registers u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // register update for one event, then queue the view the block should report
   task automatic predict_scroll_event(input logic [3:0] func, input logic [7:0] value,
                                       input logic rendering);
      logic [14:0]     step;
      logic [4:0]      row;
      scroll_view_type view;
      step = inc_by_row ? 15'd32 : 15'd1;
      case (func)
         vsar_pkg::FUNC_CTRL_WR: begin
            tmp_addr[11:10] = value[1:0];
            inc_by_row      = value[2];
         end
         vsar_pkg::FUNC_SCROLL_WR: begin
            if (!toggle) begin
               tmp_addr[4:0] = value[7:3];
               fine_x        = value[2:0];
            end else begin
               tmp_addr[9:5]   = value[7:3];
               tmp_addr[14:12] = value[2:0];
            end
            toggle = ~toggle;
         end
         vsar_pkg::FUNC_ADDR_WR: begin
            if (!toggle) begin
               tmp_addr[14:8] = {1'b0, value[5:0]};
            end else begin
               tmp_addr[7:0] = value;
               cur_addr      = tmp_addr;
            end
            toggle = ~toggle;
         end
         vsar_pkg::FUNC_STATUS_RD: toggle = 1'b0;
         vsar_pkg::FUNC_DATA_RD:   cur_addr = cur_addr + step;
         vsar_pkg::FUNC_DATA_WR:   cur_addr = cur_addr + (rendering ? 15'd33 : step);
         vsar_pkg::FUNC_INC_HORIZ: begin
            if (cur_addr[4:0] == 5'd31) begin
               cur_addr[4:0] = '0;
               cur_addr[10]  = ~cur_addr[10];
            end else begin
               cur_addr[4:0] = cur_addr[4:0] + 5'd1;
            end
         end
         vsar_pkg::FUNC_INC_VERT: begin
            if (cur_addr[14:12] != 3'd7) begin
               cur_addr[14:12] = cur_addr[14:12] + 3'd1;
            end else begin
               cur_addr[14:12] = '0;
               row = cur_addr[9:5];
               if (row == 5'd29) begin
                  row          = '0;
                  cur_addr[11] = ~cur_addr[11];
               end else if (row == 5'd31) begin
                  row = '0;
               end else begin
                  row = row + 5'd1;
               end
               cur_addr[9:5] = row;
            end
         end
         vsar_pkg::FUNC_COPY_HORIZ: begin
            cur_addr = (cur_addr & 15'h7be0) | (tmp_addr & 15'h041f);
         end
         vsar_pkg::FUNC_COPY_VERT: begin
            cur_addr = (cur_addr & 15'h041f) | (tmp_addr & 15'h7be0);
         end
         default: ;
      endcase
      view.cur_addr     = cur_addr;
      view.tmp_addr     = tmp_addr;
      view.fine_x       = fine_x;
      view.second_write = toggle;
      view.tile_addr    = {2'b10, cur_addr[11:0]};
      // attribute byte: name table, coarse y / 4, coarse x / 4
      view.attr_addr    = {2'b10, cur_addr[11:10], 4'b1111, cur_addr[9:7], cur_addr[4:2]};
      view.fine_y       = cur_addr[14:12];
      expected_views.push_back(view);
   endtask

   task automatic send_event(input logic [3:0] func, input logic [7:0] value,
                             input logic rendering);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'b0, rendering, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_scroll_event(func, value, rendering);
   endtask

   task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // receiver side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (rx_hold_left > 0) begin
         rsp_tready   <= 1'b0;
         rx_hold_left <= rx_hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_views.size() == 0) begin
            $error("result beat with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            oldest_view = expected_views.pop_front();
            check_field("current_address", int'(oldest_view.cur_addr),
                        int'(rsp_tdata[14:0]));
            check_field("temp_address", int'(oldest_view.tmp_addr),
                        int'(rsp_tdata[29:15]));
            check_field("fine_x", int'(oldest_view.fine_x), int'(rsp_tdata[32:30]));
            check_field("second_write", int'(oldest_view.second_write),
                        int'(rsp_tdata[33]));
            check_field("tile_fetch_address", int'(oldest_view.tile_addr),
                        int'(rsp_tdata[47:34]));
            check_field("attribute_fetch_address", int'(oldest_view.attr_addr),
                        int'(rsp_tdata[61:48]));
            check_field("fine_y", int'(oldest_view.fine_y), int'(rsp_tdata[64:62]));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("video_scroll_address_registers_test: errors");
         $finish;
      end
   end

   task automatic test_directed();
      set_idling(0, 0);
      send_event(vsar_pkg::FUNC_CTRL_WR, 8'hff, 1'b0);
      send_event(vsar_pkg::FUNC_DATA_RD, 8'h00, 1'b0);     // row step
      send_event(vsar_pkg::FUNC_CTRL_WR, 8'h00, 1'b1);
      send_event(vsar_pkg::FUNC_DATA_RD, 8'hff, 1'b1);     // unit step
      send_event(vsar_pkg::FUNC_DATA_WR, 8'h00, 1'b0);
      send_event(vsar_pkg::FUNC_DATA_WR, 8'h00, 1'b1);     // render step of 33
      send_event(vsar_pkg::FUNC_ADDR_WR, 8'hff, 1'b0);
      send_event(vsar_pkg::FUNC_STATUS_RD, 8'h00, 1'b0);   // drops the half-done address write
      send_event(vsar_pkg::FUNC_ADDR_WR, 8'h3f, 1'b0);
      send_event(vsar_pkg::FUNC_ADDR_WR, 8'hff, 1'b0);
      // coarse x 31, fine y 7, coarse y 31, both name tables: all ones
      send_event(vsar_pkg::FUNC_SCROLL_WR, 8'hff, 1'b0);
      send_event(vsar_pkg::FUNC_SCROLL_WR, 8'hff, 1'b0);
      send_event(vsar_pkg::FUNC_CTRL_WR, 8'h03, 1'b0);
      send_event(vsar_pkg::FUNC_COPY_HORIZ, 8'h00, 1'b1);
      send_event(vsar_pkg::FUNC_COPY_VERT, 8'h00, 1'b1);
      send_event(vsar_pkg::FUNC_DATA_WR, 8'h00, 1'b1);     // wraps at 15 bits
      send_event(vsar_pkg::FUNC_INC_HORIZ, 8'h00, 1'b1);
      send_event(vsar_pkg::FUNC_COPY_VERT, 8'h00, 1'b1);
      send_event(vsar_pkg::FUNC_INC_VERT, 8'h00, 1'b1);    // coarse y 31 wraps without flip
      // fine y 7 and coarse y 29: wraps and flips the vertical name table
      send_event(vsar_pkg::FUNC_SCROLL_WR, 8'h00, 1'b0);
      send_event(vsar_pkg::FUNC_SCROLL_WR, 8'hef, 1'b0);
      send_event(vsar_pkg::FUNC_COPY_VERT, 8'h00, 1'b1);
      send_event(vsar_pkg::FUNC_INC_VERT, 8'h00, 1'b1);
      send_event(FUNC_FIRST_UNUSED, 8'hff, 1'b1);
      send_event(FUNC_LAST_UNUSED, 8'h5a, 1'b0);
   endtask

   // processor traffic: mostly complete write pairs, some strays and noise
   task automatic test_cpu_traffic(input int count);
      int pick;
      int sent;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            if ($urandom_range(0, 1)) begin
               send_event(vsar_pkg::FUNC_STATUS_RD, 8'($urandom), 1'($urandom));
               sent++;
            end
            send_event(vsar_pkg::FUNC_SCROLL_WR, 8'($urandom), 1'($urandom));
            send_event(vsar_pkg::FUNC_SCROLL_WR, 8'($urandom), 1'($urandom));
            sent += 2;
         end else if (pick < 40) begin
            send_event(vsar_pkg::FUNC_ADDR_WR, 8'($urandom), 1'($urandom));
            send_event(vsar_pkg::FUNC_ADDR_WR, 8'($urandom), 1'($urandom));
            sent += 2;
         end else if (pick < 50) begin
            send_event(vsar_pkg::FUNC_CTRL_WR, 8'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 65) begin
            send_event($urandom_range(0, 1) ? vsar_pkg::FUNC_DATA_RD : vsar_pkg::FUNC_DATA_WR,
                       8'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 78) begin
            send_event(4'($urandom_range(vsar_pkg::FUNC_INC_HORIZ, vsar_pkg::FUNC_COPY_VERT)),
                       8'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 82) begin
            send_event(4'($urandom_range(FUNC_FIRST_UNUSED, FUNC_LAST_UNUSED)),
                       8'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 90) begin
            send_event($urandom_range(0, 1) ? vsar_pkg::FUNC_SCROLL_WR : vsar_pkg::FUNC_ADDR_WR,
                       8'($urandom), 1'($urandom));
            sent++;
         end else begin
            send_event(vsar_pkg::FUNC_STATUS_RD, 8'($urandom), 1'($urandom));
            sent++;
         end
      end
   endtask

   // render-time pattern: horizontal steps along a line, then the line-end updates
   task automatic test_render_lines(input int lines);
      int span;
      for (int line = 0; line < lines; line++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_event(vsar_pkg::FUNC_COPY_VERT, 8'($urandom), 1'b1);
         end
         span = $urandom_range(1, 34);
         repeat (span) begin
            if ($urandom_range(0, 15) == 0) begin
               send_event(vsar_pkg::FUNC_DATA_WR, 8'($urandom), 1'b1);
            end else begin
               send_event(vsar_pkg::FUNC_INC_HORIZ, 8'($urandom), 1'b1);
            end
         end
         send_event(vsar_pkg::FUNC_INC_VERT, 8'($urandom), 1'b1);
         send_event(vsar_pkg::FUNC_COPY_HORIZ, 8'($urandom), 1'b1);
      end
   endtask

   // receiver holds off for a long stretch while events keep coming
   task automatic test_backpressure();
      set_idling(0, 0);
      rx_hold_left = LONG_HOLD_CYCLES;
      test_cpu_traffic(30);
      test_render_lines(1);
   endtask

   task automatic finish_run();
      req_tvalid <= 1'b0;
      while (expected_views.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("video_scroll_address_registers_test: clean");
      end else begin
         $display("video_scroll_address_registers_test: errors");
      end
      $finish;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_idling(0, 0);
      test_cpu_traffic(180);
      test_render_lines(3);
      set_idling(70, 0);
      test_cpu_traffic(180);
      test_render_lines(3);
      set_idling(0, 70);
      test_cpu_traffic(180);
      test_render_lines(3);
      set_idling(6, 6);
      test_cpu_traffic(180);
      test_render_lines(3);
      test_backpressure();
      finish_run();
   end

endmodule

[sim.f]
hw/rtl/vsar_pkg.sv
hw/rtl/vsar_step.sv
hw/rtl/video_scroll_address_registers.sv
test/video_scroll_address_registers_test.sv
